// ===== rtl/cts_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package cts_pkg;

  localparam int BUTTON_W  = 2;
  localparam int HOURS_W   = 5;
  localparam int MINUTES_W = 6;
  localparam int DIGIT_W   = 2;
  localparam int TIMEOUT_W = 16;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = TIMEOUT_W'(10 * 1024);

  localparam logic [HOURS_W-1:0]   HOURS_MOD   = HOURS_W'(24);
  localparam logic [MINUTES_W-1:0] MINUTES_MOD = MINUTES_W'(60);

  // Button event codes; the fourth code is unused and behaves as idle.
  typedef enum logic [BUTTON_W-1:0] {
    BTN_IDLE  = 2'd0,
    BTN_SHORT = 2'd1,
    BTN_LONG  = 2'd2
  } button_t;

  localparam logic [DIGIT_W-1:0] DIGIT_HOUR_TENS   = 2'd0;
  localparam logic [DIGIT_W-1:0] DIGIT_HOUR_ONES   = 2'd1;
  localparam logic [DIGIT_W-1:0] DIGIT_MINUTE_TENS = 2'd2;
  localparam logic [DIGIT_W-1:0] DIGIT_MINUTE_ONES = 2'd3;

  typedef struct packed {
    logic [BUTTON_W-1:0]  button;
    logic [HOURS_W-1:0]   clock_hours;
    logic [MINUTES_W-1:0] clock_minutes;
  } cts_event_t;

  typedef struct packed {
    logic                 in_set_mode;
    logic [DIGIT_W-1:0]   selected_digit;
    logic [HOURS_W-1:0]   edit_hours;
    logic [MINUTES_W-1:0] edit_minutes;
    logic                 commit;
  } cts_result_t;

endpackage

`default_nettype wire

// ===== rtl/cts_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface cts_in_if import cts_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [BUTTON_W-1:0]  button;
  logic [HOURS_W-1:0]   clock_hours;
  logic [MINUTES_W-1:0] clock_minutes;

  modport source (output valid, output button, output clock_hours,
                  output clock_minutes, input ready);
  modport sink   (input valid, input button, input clock_hours,
                  input clock_minutes, output ready);
endinterface

interface cts_out_if import cts_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 in_set_mode;
  logic [DIGIT_W-1:0]   selected_digit;
  logic [HOURS_W-1:0]   edit_hours;
  logic [MINUTES_W-1:0] edit_minutes;
  logic                 commit;

  modport source (output valid, output in_set_mode, output selected_digit,
                  output edit_hours, output edit_minutes, output commit,
                  input ready);
  modport sink   (input valid, input in_set_mode, input selected_digit,
                  input edit_hours, input edit_minutes, input commit,
                  output ready);
endinterface

interface cts_cfg_if import cts_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [TIMEOUT_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/clock_time_set_controller.sv =====
// Single-button time-setting controller for a clock.
// in_ch  : one button event per transaction (idle, short press, long press)
//          together with the clock's current hours and minutes.
// out_ch : one result per event: mode after the event, selected digit,
//          edited hours and minutes, and a commit strobe.
// cfg_ch : writes the idle timeout reload value (ticks allowed in set mode).
// Use: a long press in display mode captures the clock time and enters set
// mode on the hour-tens digit. Short presses bump the selected digit, long
// presses step to the next digit, and a long press on the last digit
// commits. Idle events count down the timeout; at zero set mode is dropped.
// Timing: an event is registered on acceptance and its result is registered
// once the result register is free, so a result held on out_ch delays it.
// Throughput is one event per cycle unless out_ch stalls; the next event uses
// the state the previous one left, updated in the same edge as its result.
// Reset: display mode, digit 0, edit values 0, countdown 0, reload 10240;
// both channels empty. cfg_ch is always ready.
// Stall: a result held by the receiver stays on out_ch, one more event waits
// in the input register, and in_ch drops ready only when both are full.
`timescale 1ns / 1ps
`default_nettype none

module clock_time_set_controller import cts_pkg::*; (
  input  wire      clk,
  input  wire      rst_n,
  cts_in_if.sink   in_ch,
  cts_out_if.source out_ch,
  cts_cfg_if.sink  cfg_ch
);

  // Input register
  logic        s1_valid_r;
  cts_event_t  s1_r;

  // Result register
  logic        out_valid_r;
  cts_result_t out_r;

  // Controller state
  logic                 set_mode_r,    set_mode_nxt;
  logic [DIGIT_W-1:0]   digit_r,       digit_nxt;
  logic [HOURS_W-1:0]   hours_r,       hours_nxt;
  logic [MINUTES_W-1:0] minutes_r,     minutes_nxt;
  logic [TIMEOUT_W-1:0] countdown_r,   countdown_nxt;
  logic [TIMEOUT_W-1:0] reload_r;
  logic                 commit_nxt;

  logic advance;   // stage 1 moves into the result register
  logic in_fire;

  assign advance = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || advance;
  assign in_fire = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  // Bump helpers: state values are always in range, so one compare fixes wrap.
  logic [HOURS_W:0]     hours_p10, hours_p1;
  logic [MINUTES_W:0]   minutes_p10, minutes_p1;
  logic [TIMEOUT_W-1:0] countdown_dec;

  assign hours_p10   = {1'b0, hours_r} + (HOURS_W + 1)'(10);
  assign hours_p1    = {1'b0, hours_r} + (HOURS_W + 1)'(1);
  assign minutes_p10 = {1'b0, minutes_r} + (MINUTES_W + 1)'(10);
  assign minutes_p1  = {1'b0, minutes_r} + (MINUTES_W + 1)'(1);
  assign countdown_dec = (countdown_r != '0) ? countdown_r - TIMEOUT_W'(1) : countdown_r;

  always_comb begin
    set_mode_nxt  = set_mode_r;
    digit_nxt     = digit_r;
    hours_nxt     = hours_r;
    minutes_nxt   = minutes_r;
    countdown_nxt = countdown_r;
    commit_nxt    = 1'b0;

    if (!set_mode_r) begin
      if (s1_r.button == BTN_LONG) begin
        // Capture the clock; out-of-range values fold back once.
        hours_nxt     = (s1_r.clock_hours >= HOURS_MOD) ?
                        s1_r.clock_hours - HOURS_MOD : s1_r.clock_hours;
        minutes_nxt   = (s1_r.clock_minutes >= MINUTES_MOD) ?
                        s1_r.clock_minutes - MINUTES_MOD : s1_r.clock_minutes;
        digit_nxt     = DIGIT_HOUR_TENS;
        countdown_nxt = reload_r;
        set_mode_nxt  = 1'b1;
      end
    end else begin
      case (s1_r.button)
        BTN_SHORT: begin
          countdown_nxt = reload_r;
          case (digit_r)
            DIGIT_HOUR_TENS: begin
              hours_nxt = (hours_p10 >= {1'b0, HOURS_MOD}) ?
                          HOURS_W'(hours_p10 - {1'b0, HOURS_MOD}) : HOURS_W'(hours_p10);
            end
            DIGIT_HOUR_ONES: begin
              hours_nxt = (hours_p1 >= {1'b0, HOURS_MOD}) ? '0 : HOURS_W'(hours_p1);
            end
            DIGIT_MINUTE_TENS: begin
              minutes_nxt = (minutes_p10 >= {1'b0, MINUTES_MOD}) ?
                            MINUTES_W'(minutes_p10 - {1'b0, MINUTES_MOD}) :
                            MINUTES_W'(minutes_p10);
            end
            default: begin
              minutes_nxt = (minutes_p1 >= {1'b0, MINUTES_MOD}) ? '0 : MINUTES_W'(minutes_p1);
            end
          endcase
        end
        BTN_LONG: begin
          countdown_nxt = reload_r;
          if (digit_r == DIGIT_MINUTE_ONES) begin
            commit_nxt   = 1'b1;
            set_mode_nxt = 1'b0;
            digit_nxt    = DIGIT_HOUR_TENS;
          end else begin
            digit_nxt = digit_r + DIGIT_W'(1);
          end
        end
        default: begin
          // Idle, and the unused code: count down and drop out at zero.
          countdown_nxt = countdown_dec;
          if (countdown_dec == '0) begin
            set_mode_nxt = 1'b0;
          end
        end
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      set_mode_r  <= 1'b0;
      digit_r     <= '0;
      hours_r     <= '0;
      minutes_r   <= '0;
      countdown_r <= '0;
      reload_r    <= TIMEOUT_RESET;
    end else begin
      if (in_ch.ready) begin
        s1_valid_r <= in_ch.valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (advance) begin
        set_mode_r  <= set_mode_nxt;
        digit_r     <= digit_nxt;
        hours_r     <= hours_nxt;
        minutes_r   <= minutes_nxt;
        countdown_r <= countdown_nxt;
      end
      if (cfg_ch.valid) begin
        reload_r <= cfg_ch.data;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_r.button        <= in_ch.button;
      s1_r.clock_hours   <= in_ch.clock_hours;
      s1_r.clock_minutes <= in_ch.clock_minutes;
    end
    if (advance) begin
      out_r.in_set_mode    <= set_mode_nxt;
      out_r.selected_digit <= digit_nxt;
      out_r.edit_hours     <= hours_nxt;
      out_r.edit_minutes   <= minutes_nxt;
      out_r.commit         <= commit_nxt;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.in_set_mode    = out_r.in_set_mode;
  assign out_ch.selected_digit = out_r.selected_digit;
  assign out_ch.edit_hours     = out_r.edit_hours;
  assign out_ch.edit_minutes   = out_r.edit_minutes;
  assign out_ch.commit         = out_r.commit;

  // A commit always returns to display mode on the first digit.
  a_commit_exits: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.commit) |->
      (!out_r.in_set_mode && out_r.selected_digit == DIGIT_HOUR_TENS))
    else $error("commit without return to display on digit 0");

  // Edit values never leave their ranges.
  a_hours_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.edit_hours < HOURS_MOD))
    else $error("edit hours out of range");

  a_minutes_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.edit_minutes < MINUTES_MOD))
    else $error("edit minutes out of range");

  // A waiting event is not lost while the result register is blocked.
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !advance) |=> (s1_valid_r && $stable(s1_r)))
    else $error("pending event dropped during stall");

  // State only changes when an event moves to the result register.
  a_state_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> ($stable(set_mode_r) && $stable(digit_r) && $stable(countdown_r)))
    else $error("state changed without an event");

endmodule

`default_nettype wire

// ===== bench/tb_clock_time_set_controller.sv =====
`timescale 1ns / 1ps

module tb_clock_time_set_controller;
  import cts_pkg::*;

  // Fourth button code: not a real event, the block must treat it as idle.
  localparam logic [BUTTON_W-1:0] BTN_UNUSED = 2'd3;

  localparam int HOLD_CYCLES = 400;   // long receiver hold-off
  localparam int QUIET_LIMIT = 2000;  // cycles with no transaction on any channel
  localparam int PHASE_ITEMS = 280;   // session events per random phase

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  cts_in_if  in_bus ();
  cts_out_if out_bus ();
  cts_cfg_if cfg_bus ();

  clock_time_set_controller DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus),
    .cfg_ch (cfg_bus)
  );

  // ---------------------------------------------------------------------------
  // Time-setter model: mirrors the controller state, advanced once per accepted
  // input transaction. Only the checker process below writes these.
  // ---------------------------------------------------------------------------
  logic                 setting_active;
  logic [DIGIT_W-1:0]   cursor_digit;
  logic [HOURS_W-1:0]   hours_shadow;
  logic [MINUTES_W-1:0] minutes_shadow;
  logic [TIMEOUT_W-1:0] idle_left;
  logic [TIMEOUT_W-1:0] idle_reload;

  cts_result_t expected_readouts [$];
  int mismatch_count = 0;

  // Typed expectation riding alongside the input transaction (directed rows).
  // Driven with the payload so the checker samples both at the same edge.
  logic        typed_pending = 1'b0;
  cts_result_t typed_readout = '0;

  // Knobs for the random phases.
  int gap_pct = 0;         // sender idle chance per cycle, main process only
  int stall_pct = 0;       // receiver stall chance per cycle
  int hold_requested = 0;  // bumped by main to ask the receiver for a hold-off

  function automatic cts_result_t apply_button_event(input logic [BUTTON_W-1:0] btn,
                                                     input logic [HOURS_W-1:0] clk_hours,
                                                     input logic [MINUTES_W-1:0] clk_minutes);
    cts_result_t r;
    logic        strobe;
    int          sum;
    strobe = 1'b0;
    if (!setting_active) begin
      // Display mode: only a long press matters, it captures the clock time.
      if (btn == BTN_LONG) begin
        hours_shadow   = (clk_hours >= HOURS_MOD) ? clk_hours - HOURS_MOD : clk_hours;
        minutes_shadow = (clk_minutes >= MINUTES_MOD) ? clk_minutes - MINUTES_MOD
                                                      : clk_minutes;
        cursor_digit   = DIGIT_HOUR_TENS;
        idle_left      = idle_reload;
        setting_active = 1'b1;
      end
    end else if (btn == BTN_SHORT) begin
      idle_left = idle_reload;
      case (cursor_digit)
        DIGIT_HOUR_TENS: begin
          sum = hours_shadow + 10;
          hours_shadow = HOURS_W'(sum % HOURS_MOD);
        end
        DIGIT_HOUR_ONES: begin
          sum = hours_shadow + 1;
          hours_shadow = HOURS_W'(sum % HOURS_MOD);
        end
        DIGIT_MINUTE_TENS: begin
          sum = minutes_shadow + 10;
          minutes_shadow = MINUTES_W'(sum % MINUTES_MOD);
        end
        default: begin
          sum = minutes_shadow + 1;
          minutes_shadow = MINUTES_W'(sum % MINUTES_MOD);
        end
      endcase
    end else if (btn == BTN_LONG) begin
      idle_left = idle_reload;
      if (cursor_digit == DIGIT_MINUTE_ONES) begin
        strobe         = 1'b1;
        setting_active = 1'b0;
        cursor_digit   = DIGIT_HOUR_TENS;
      end else begin
        cursor_digit = cursor_digit + 1'b1;
      end
    end else begin
      // Idle tick (the unused code lands here too). Zero reload exits at once.
      if (idle_left != '0) idle_left = idle_left - 1'b1;
      if (idle_left == '0) setting_active = 1'b0;
    end
    r.in_set_mode    = setting_active;
    r.selected_digit = cursor_digit;
    r.edit_hours     = hours_shadow;
    r.edit_minutes   = minutes_shadow;
    r.commit         = strobe;
    return r;
  endfunction

  function automatic void compare_field(input string field, input logic [15:0] want,
                                        input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatch_count++;
    end
  endfunction

  // Checker: results first, then config, then new input, all at one edge.
  // An input accepted at this edge cannot have its result at the same edge.
  always @(posedge clk) begin
    cts_result_t want;
    if (!rst_n) begin
      setting_active = 1'b0;
      cursor_digit   = DIGIT_HOUR_TENS;
      hours_shadow   = '0;
      minutes_shadow = '0;
      idle_left      = '0;
      idle_reload    = TIMEOUT_RESET;
      expected_readouts.delete();
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (expected_readouts.size() == 0) begin
          $error("unexpected result transaction: mode %0d digit %0d time %0d:%0d commit %0d",
                 out_bus.in_set_mode, out_bus.selected_digit, out_bus.edit_hours,
                 out_bus.edit_minutes, out_bus.commit);
          mismatch_count++;
        end else begin
          want = expected_readouts.pop_front();
          compare_field("in_set_mode", 16'(want.in_set_mode), 16'(out_bus.in_set_mode));
          compare_field("selected_digit", 16'(want.selected_digit),
                        16'(out_bus.selected_digit));
          compare_field("edit_hours", 16'(want.edit_hours), 16'(out_bus.edit_hours));
          compare_field("edit_minutes", 16'(want.edit_minutes), 16'(out_bus.edit_minutes));
          compare_field("commit", 16'(want.commit), 16'(out_bus.commit));
        end
      end
      if (cfg_bus.valid && cfg_bus.ready) idle_reload = cfg_bus.data;
      if (in_bus.valid && in_bus.ready) begin
        want = apply_button_event(in_bus.button, in_bus.clock_hours, in_bus.clock_minutes);
        if (typed_pending) want = typed_readout;
        expected_readouts.push_back(want);
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off counted here on request.
  initial begin
    int hold_left;
    int hold_granted;
    hold_left = 0;
    hold_granted = 0;
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left != 0) begin
        out_bus.ready <= 1'b0;
        hold_left = hold_left - 1;
      end else if (hold_granted != hold_requested) begin
        hold_granted = hold_requested;
        hold_left = HOLD_CYCLES;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // Watchdog: a stuck channel or a lost result ends the run here.
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
          (cfg_bus.valid && cfg_bus.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driver side
  // ---------------------------------------------------------------------------

  // One input transaction; returns at the accepting edge or after the gap.
  // valid is left high when no gap follows, so back-to-back items stream.
  task automatic send_event(input logic [BUTTON_W-1:0] btn, input logic [HOURS_W-1:0] hrs,
                            input logic [MINUTES_W-1:0] mins, input logic has_typed,
                            input cts_result_t typed_val);
    in_bus.valid         <= 1'b1;
    in_bus.button        <= btn;
    in_bus.clock_hours   <= hrs;
    in_bus.clock_minutes <= mins;
    typed_pending        <= has_typed;
    typed_readout        <= typed_val;
    do @(posedge clk); while (!in_bus.ready);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Expectations are checked at the falling edge so the checker has settled.
  task automatic wait_readouts_drained();
    do @(negedge clk); while (expected_readouts.size() != 0);
    @(posedge clk);
  endtask

  task automatic write_timeout(input logic [TIMEOUT_W-1:0] value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.data  <= value;
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
  endtask

  // Random phase: mostly edit sessions (long press to enter, then a burst of
  // presses and idle ticks), with some stray events of any code in between.
  task automatic run_edit_sessions(input int target, input int gap, input int stall,
                                   input bit with_hold);
    int done;
    int pick;
    bit drained_once;
    bit held;
    logic [BUTTON_W-1:0] btn;
    done = 0;
    drained_once = 1'b0;
    held = 1'b0;
    gap_pct = gap;
    stall_pct <= stall;
    while (done < target) begin
      if ($urandom_range(0, 99) < 15) begin
        send_event(BUTTON_W'($urandom_range(0, 3)), HOURS_W'($urandom_range(0, 31)),
                   MINUTES_W'($urandom_range(0, 63)), 1'b0, '0);
      end else begin
        send_event(BTN_LONG, HOURS_W'($urandom_range(0, 31)),
                   MINUTES_W'($urandom_range(0, 63)), 1'b0, '0);
        done++;
        repeat ($urandom_range(1, 14)) begin
          pick = $urandom_range(0, 99);
          if (pick < 50)      btn = BTN_SHORT;
          else if (pick < 78) btn = BTN_LONG;
          else if (pick < 95) btn = BTN_IDLE;
          else                btn = BTN_UNUSED;
          send_event(btn, HOURS_W'($urandom_range(0, 31)),
                     MINUTES_W'($urandom_range(0, 63)), 1'b0, '0);
          done++;
        end
      end
      // Receiver goes deaf for a while; the sender keeps pushing and backs up.
      if (with_hold && !held && done >= target / 4) begin
        hold_requested <= hold_requested + 1;
        held = 1'b1;
      end
      // Sender pauses until every result is back.
      if (!drained_once && done >= target / 2) begin
        in_bus.valid <= 1'b0;
        wait_readouts_drained();
        drained_once = 1'b1;
      end
    end
    in_bus.valid <= 1'b0;
    wait_readouts_drained();
  endtask

  // ---------------------------------------------------------------------------
  // Directed table: a row is either a button event or a timeout write.
  // Typed expectations only where obvious; other rows use the model.
  // ---------------------------------------------------------------------------
  typedef struct {
    bit                   is_cfg;
    logic [TIMEOUT_W-1:0] cfg_value;
    logic [BUTTON_W-1:0]  button;
    logic [HOURS_W-1:0]   hours;
    logic [MINUTES_W-1:0] minutes;
    bit                   has_typed;
    cts_result_t          typed;
  } step_row_t;

  function automatic step_row_t ev(input logic [BUTTON_W-1:0] btn,
                                   input logic [HOURS_W-1:0] hrs,
                                   input logic [MINUTES_W-1:0] mins);
    step_row_t r;
    r = '{is_cfg: 1'b0, cfg_value: '0, button: btn, hours: hrs, minutes: mins,
          has_typed: 1'b0, typed: '0};
    return r;
  endfunction

  function automatic step_row_t ev_typed(input logic [BUTTON_W-1:0] btn,
                                         input logic [HOURS_W-1:0] hrs,
                                         input logic [MINUTES_W-1:0] mins,
                                         input logic mode, input logic [DIGIT_W-1:0] digit,
                                         input logic [HOURS_W-1:0] eh,
                                         input logic [MINUTES_W-1:0] em, input logic strobe);
    step_row_t r;
    r = ev(btn, hrs, mins);
    r.has_typed = 1'b1;
    r.typed.in_set_mode    = mode;
    r.typed.selected_digit = digit;
    r.typed.edit_hours     = eh;
    r.typed.edit_minutes   = em;
    r.typed.commit         = strobe;
    return r;
  endfunction

  function automatic step_row_t cfg_row(input logic [TIMEOUT_W-1:0] value);
    step_row_t r;
    r = ev(BTN_IDLE, '0, '0);
    r.is_cfg = 1'b1;
    r.cfg_value = value;
    return r;
  endfunction

  step_row_t directed_steps [$];

  initial begin
    in_bus.valid         <= 1'b0;
    in_bus.button        <= BTN_IDLE;
    in_bus.clock_hours   <= '0;
    in_bus.clock_minutes <= '0;
    cfg_bus.valid        <= 1'b0;
    cfg_bus.data         <= '0;

    directed_steps = '{
      // straight out of reset: all zero, display mode
      ev_typed(BTN_IDLE, 5'd0, 6'd0, 1'b0, DIGIT_HOUR_TENS, 5'd0, 6'd0, 1'b0),
      // short press in display mode does nothing
      ev_typed(BTN_SHORT, 5'd5, 6'd5, 1'b0, DIGIT_HOUR_TENS, 5'd0, 6'd0, 1'b0),
      // unused code in display mode, out-of-range clock ignored too
      ev_typed(BTN_UNUSED, 5'd31, 6'd63, 1'b0, DIGIT_HOUR_TENS, 5'd0, 6'd0, 1'b0),
      // capture the latest legal time
      ev_typed(BTN_LONG, 5'd23, 6'd59, 1'b1, DIGIT_HOUR_TENS, 5'd23, 6'd59, 1'b0),
      ev(BTN_SHORT, 5'd0, 6'd0),     // hour tens wraps past 24
      ev(BTN_SHORT, 5'd0, 6'd0),
      ev(BTN_UNUSED, 5'd0, 6'd0),    // unused code in set mode ticks like idle
      ev(BTN_LONG, 5'd0, 6'd0),
      ev(BTN_SHORT, 5'd0, 6'd0),
      ev(BTN_LONG, 5'd0, 6'd0),
      ev(BTN_SHORT, 5'd0, 6'd0),     // minute tens wraps past 60
      ev(BTN_LONG, 5'd0, 6'd0),
      ev(BTN_SHORT, 5'd0, 6'd0),
      ev(BTN_LONG, 5'd0, 6'd0),      // commit on the last digit
      cfg_row(16'd2),
      ev(BTN_LONG, 5'd31, 6'd63),    // out-of-range capture folds down
      ev(BTN_LONG, 5'd0, 6'd0),
      ev(BTN_IDLE, 5'd0, 6'd0),
      ev(BTN_SHORT, 5'd0, 6'd0),     // press reloads the countdown
      ev(BTN_IDLE, 5'd0, 6'd0),
      ev(BTN_IDLE, 5'd0, 6'd0),      // timeout: leave set mode, digit kept
      cfg_row(16'd0),
      ev_typed(BTN_LONG, 5'd24, 6'd60, 1'b1, DIGIT_HOUR_TENS, 5'd0, 6'd0, 1'b0),
      // zero reload: first idle tick drops set mode
      ev_typed(BTN_IDLE, 5'd0, 6'd0, 1'b0, DIGIT_HOUR_TENS, 5'd0, 6'd0, 1'b0),
      cfg_row(16'hFFFF),
      ev(BTN_LONG, 5'd0, 6'd0),
      ev(BTN_IDLE, 5'd0, 6'd0),
      ev(BTN_SHORT, 5'd0, 6'd0)
    };

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_steps[i]) begin
      if (directed_steps[i].is_cfg) begin
        in_bus.valid <= 1'b0;
        wait_readouts_drained();
        write_timeout(directed_steps[i].cfg_value);
      end else begin
        send_event(directed_steps[i].button, directed_steps[i].hours,
                   directed_steps[i].minutes, directed_steps[i].has_typed,
                   directed_steps[i].typed);
      end
    end
    in_bus.valid <= 1'b0;
    wait_readouts_drained();

    // Shortest nonzero timeout, full rate both sides.
    write_timeout(16'd1);
    run_edit_sessions(PHASE_ITEMS, 0, 0, 1'b0);
    // Longest timeout, sender mostly idle.
    write_timeout(16'hFFFF);
    run_edit_sessions(PHASE_ITEMS, 68, 0, 1'b0);
    // Short timeout, receiver stalling, with the long hold-off.
    write_timeout(16'd4);
    run_edit_sessions(PHASE_ITEMS, 0, 68, 1'b1);
    // Random small timeout, both sides idling.
    write_timeout(TIMEOUT_W'($urandom_range(2, 9)));
    run_edit_sessions(PHASE_ITEMS, 37, 37, 1'b0);

    // Extra edges after the drain catch any stray result.
    repeat (6) @(posedge clk);
    if (mismatch_count == 0 && expected_readouts.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/cts_pkg.sv
rtl/cts_if.sv
rtl/clock_time_set_controller.sv
bench/tb_clock_time_set_controller.sv
